>>> rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg: shared definitions for the array priority queue
// Widths, reset constants, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned PRIO_W        = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned ENTRY_W       = PRIO_W + VALUE_W;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned OCC_W         = 7;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic    latch_req;
    logic    ins_write;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    result_load;
    status_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic op_delete;
    logic full;
    logic empty;
    logic scan_last;
    logic shift_more;
  } dp_status_t;

  // Order-preserving unsigned key of a two's-complement priority.
  function automatic logic [PRIO_W-1:0] prio_key(input logic [PRIO_W-1:0] p);
    prio_key = {~p[PRIO_W-1], p[PRIO_W-2:0]};
  endfunction

endpackage

>>> rtl/apq_if.sv
// ----------------------------------------------------------------------------
// apq_if: request, response and configuration channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface apq_req_if;
  logic                valid;
  logic                ready;
  logic                op;
  logic signed [15:0]  priority_req;
  logic signed [31:0]  value;

  modport source (output valid, op, priority_req, value, input ready);
  modport sink   (input valid, op, priority_req, value, output ready);
endinterface

interface apq_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic signed [15:0]  out_priority;
  logic signed [31:0]  out_value;
  logic [6:0]          occupancy;

  modport source (output valid, status, out_priority, out_value, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_value, occupancy, output ready);
endinterface

interface apq_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// array_priority_queue_unit: bounded priority queue over an unsorted array
//
// A request on req_i either inserts a (priority, value) pair at the tail or
// deletes the entry of greatest signed priority, the earliest one on ties.
// Each request yields exactly one response on rsp_o carrying a status code,
// the removed entry for a successful delete (zero otherwise) and the
// occupancy after the request. The capacity register is written through
// cfg_i, which is always ready; inserts are refused once the occupancy
// reaches the smaller of the capacity and DEPTH.
// Requests are handled one at a time. An insert or a refused request
// passes through the EXEC and RESULT states before its response is
// registered. A successful delete first makes one pass over the RAM read
// port to find the maximum, then moves one entry per cycle down to close
// the gap left by the winner, both set by the single RAM port pair.
// The response sits in an output register; while it waits, the next request
// is already accepted and worked on, and only its response stalls.
// Reset empties the queue and sets the capacity to 64; the entry RAM is not
// cleared, as only entries below the occupancy are ever used.
// ----------------------------------------------------------------------------
module array_priority_queue_unit #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apq_req_if.sink   req_i,
  apq_rsp_if.source rsp_o,
  apq_cfg_if.sink   cfg_i
);
  import apq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The capacity register can be written in any cycle.
  assign cfg_i.ready = 1'b1;

  apq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  apq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_op_i        (req_i.op),
    .req_priority_i  (req_i.priority_req),
    .req_value_i     (req_i.value),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .rsp_status_o    (rsp_o.status),
    .rsp_priority_o  (rsp_o.out_priority),
    .rsp_value_o     (rsp_o.out_value),
    .rsp_occupancy_o (rsp_o.occupancy)
  );
endmodule

>>> rtl/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int unsigned WIDTH = apq_pkg::ENTRY_W,
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/apq_datapath.sv
// ----------------------------------------------------------------------------
// apq_datapath: entry storage, scan and shift datapath
// Holds the entry RAM, the occupancy and capacity registers, the running
// maximum of a scan, the compaction pointer and the response registers.
// ----------------------------------------------------------------------------
module apq_datapath #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_op_i,
  input  logic signed [apq_pkg::PRIO_W-1:0]  req_priority_i,
  input  logic signed [apq_pkg::VALUE_W-1:0] req_value_i,
  input  logic                              cfg_we_i,
  input  logic [apq_pkg::CAP_W-1:0]         cfg_data_i,
  input  apq_pkg::dp_cmd_t                  cmd_i,
  output apq_pkg::dp_status_t               status_o,
  output logic [apq_pkg::STATUS_W-1:0]      rsp_status_o,
  output logic signed [apq_pkg::PRIO_W-1:0]  rsp_priority_o,
  output logic signed [apq_pkg::VALUE_W-1:0] rsp_value_o,
  output logic [apq_pkg::OCC_W-1:0]         rsp_occupancy_o
);
  import apq_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic                 op_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [VALUE_W-1:0]   value_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CAP_W-1:0]     cap_q;
  logic [CW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        best_idx_q;
  logic [PRIO_W-1:0]    best_prio_q;
  logic [VALUE_W-1:0]   best_value_q;
  logic [STATUS_W-1:0]  rsp_status_q;
  logic [PRIO_W-1:0]    rsp_prio_q;
  logic [VALUE_W-1:0]   rsp_value_q;
  logic [OCC_W-1:0]     rsp_occ_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [PRIO_W-1:0]    rd_prio;
  logic [VALUE_W-1:0]   rd_value;
  logic                 scan_update;
  logic [CW-1:0]        idx_inc;
  logic                 delete_ok;

  assign rd_prio  = ram_rdata[ENTRY_W-1:VALUE_W];
  assign rd_value = ram_rdata[VALUE_W-1:0];
  assign idx_inc  = idx_q + CW'(1);

  // The first entry seeds the maximum; later ones replace it only when
  // strictly greater, so the earliest entry wins ties.
  assign scan_update = (idx_q == '0) || (prio_key(rd_prio) > prio_key(best_prio_q));

  assign status_o.op_delete  = (op_q == OP_DELETE);
  assign status_o.full       = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == DEPTH_C);
  assign status_o.empty      = (count_q == '0);
  assign status_o.scan_last  = (idx_inc == count_q);
  assign status_o.shift_more = (idx_inc < count_q);

  assign delete_ok = (op_q == OP_DELETE) && (cmd_i.kind == STATUS_OK);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = {prio_q, value_q};
    ram_raddr = '0;
    idx_d     = idx_q;
    unique case (1'b1)
      cmd_i.ins_write: begin
        ram_we = 1'b1;
      end
      cmd_i.scan_start: begin
        idx_d = '0;
      end
      cmd_i.scan_step: begin
        ram_raddr = idx_inc[AW-1:0];
        idx_d     = idx_inc;
      end
      cmd_i.shift_start: begin
        ram_raddr = AW'(CW'(best_idx_q) + CW'(1));
        idx_d     = CW'(best_idx_q);
      end
      cmd_i.shift_step: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = AW'(idx_q + CW'(2));
        idx_d     = idx_inc;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.result_load && cmd_i.kind == STATUS_OK) begin
      if (op_q == OP_DELETE) begin
        count_d = count_q - CW'(1);
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q    <= req_op_i;
      prio_q  <= req_priority_i;
      value_q <= req_value_i;
    end
    if (cmd_i.scan_step && scan_update) begin
      best_idx_q   <= idx_q[AW-1:0];
      best_prio_q  <= rd_prio;
      best_value_q <= rd_value;
    end
    if (cmd_i.result_load) begin
      rsp_status_q <= cmd_i.kind;
      rsp_prio_q   <= delete_ok ? best_prio_q : '0;
      rsp_value_q  <= delete_ok ? best_value_q : '0;
      rsp_occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_status_o    = rsp_status_q;
  assign rsp_priority_o  = rsp_prio_q;
  assign rsp_value_o     = rsp_value_q;
  assign rsp_occupancy_o = rsp_occ_q;
endmodule

>>> rtl/apq_ctrl.sv
// ----------------------------------------------------------------------------
// apq_ctrl: sequencing state machine
// Takes one request at a time, steps the datapath through scan and shift,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module apq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  apq_pkg::dp_status_t status_i,
  output apq_pkg::dp_cmd_t    cmd_o
);
  import apq_pkg::*;

  state_e  state_q, state_d;
  status_e kind_q, kind_d;
  logic    rsp_valid_q, rsp_valid_d;
  logic    slot_free;

  assign slot_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.op_delete) begin
          kind_d  = status_i.empty ? STATUS_EMPTY : STATUS_OK;
          state_d = status_i.empty ? ST_RESULT : ST_SCAN;
        end else begin
          kind_d  = status_i.full ? STATUS_FULL : STATUS_OK;
          state_d = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_SHIFT_START;
        end
      end
      ST_SHIFT_START: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!status_i.shift_more) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.latch_req = req_valid_i;
      end
      ST_EXEC: begin
        cmd_o.ins_write  = !status_i.op_delete && !status_i.full;
        cmd_o.scan_start = status_i.op_delete && !status_i.empty;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_SHIFT_START: begin
        cmd_o.shift_start = 1'b1;
      end
      ST_SHIFT: begin
        cmd_o.shift_step = status_i.shift_more;
      end
      ST_RESULT: begin
        cmd_o.result_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (cmd_o.result_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= STATUS_OK;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
endmodule
